// File: src/rdq_pkg.sv
`timescale 1ns / 1ps

package rdq_pkg;

    // fixed field widths of the request and result beats
    localparam int REQ_W = 2;
    localparam int IDX_W = 7;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ERASE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESIZE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [ST_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [ST_W-1:0] STATUS_RANGE = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MOVE,
        S_LAST,
        S_RDATA,
        S_DONE
    } state_t;

endpackage

// File: src/ring_deque_insert_erase_core.sv
`timescale 1ns / 1ps
// sequence: a rejected request goes from setup straight to the result, a read passes
// through the read-data state; insert and erase move m elements, resize writes m fills,
// and at most half the held elements move; a stalled result beat holds the sequence in
// the done state for the length of the stall
// throughput: one request at a time, the next is taken once the result is in the output register
// reset: head and count clear at once, no clearing pass; the store holds garbage until written
module ring_deque_insert_erase_core
    import rdq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [REQ_W-1:0] req_type,
    input  logic [IDX_W-1:0] index,
    input  logic [IDX_W-1:0] end_index,
    input  logic [VAL_W-1:0] value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [ST_W-1:0]  status,
    output logic [IDX_W-1:0] position_out,
    output logic [IDX_W-1:0] count_out,
    output logic [VAL_W-1:0] read_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > IDX_W) ? CW : IDX_W) + 1;

    // slot of logical index k for a head slot h
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [XW-1:0] k);
        logic [XW-1:0] s;
        s = XW'(h) + k;
        if (s >= XW'(DEPTH))
        begin
            s = s - XW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] step_up(input logic [AW-1:0] x);
        return (x == AW'(DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [AW-1:0] step_dn(input logic [AW-1:0] x);
        return (x == '0) ? AW'(DEPTH - 1) : x - 1'b1;
    endfunction

    state_t state_reg, state_next;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;

    // request held for the whole sequence
    logic [REQ_W-1:0] req_reg, req_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] end_reg, end_next;
    logic [VAL_W-1:0] val_reg, val_next;

    // move loop
    logic [AW-1:0] src_reg, src_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic [CW-1:0] moves_reg, moves_next;
    logic          dir_up_reg, dir_up_next;
    logic          fill_reg, fill_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_dst_reg, pend_dst_next;
    logic [XW-1:0] kfin_reg, kfin_next;
    logic          fin_ins_reg, fin_ins_next;
    logic          fin_head_reg, fin_head_next;

    // staged result
    logic [ST_W-1:0]  res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_pos_reg, res_pos_next;
    logic [VAL_W-1:0] res_data_reg, res_data_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [ST_W-1:0]  status_reg, status_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0] data_reg, data_next;

    // memory port
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [ELEM_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [ELEM_WIDTH-1:0] mem_rdata;
    logic [63:0]           rd_wide;
    logic [ELEM_WIDTH-1:0] val_elem;

    // shared slot unit and request checks
    logic [XW-1:0] p, e, n, dep;
    logic [XW-1:0] ka, ka_sel, kb;
    logic [AW-1:0] slot_a, slot_b;
    logic          ins_front, ers_front;
    logic          go_done, go_read;
    logic [ST_W-1:0] chk_status;
    logic          in_beat, out_free;

    assign in_beat  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign val_elem = ELEM_WIDTH'(val_reg);
    assign rd_wide  = 64'(mem_rdata);

    assign p   = XW'(idx_reg);
    assign e   = XW'(end_reg);
    assign n   = XW'(count_reg);
    assign dep = XW'(DEPTH);

    assign ins_front = (p <= n - p);
    assign ers_front = (p < n - e);

    // logical offsets fed to the two slot adders
    always_comb
    begin
        ka = '0;
        kb = '0;
        case (req_reg)
            REQ_INSERT:
            begin
                ka = n - 1'b1;
                kb = n;
            end
            REQ_ERASE:
            begin
                ka = ers_front ? p - 1'b1 : e;
                kb = ers_front ? e - 1'b1 : p;
            end
            REQ_RESIZE:
            begin
                kb = n;
            end
            REQ_READ:
            begin
                ka = p;
            end
            default:
            begin
                ka = '0;
            end
        endcase
    end

    assign ka_sel = (state_reg == S_LAST) ? kfin_reg : ka;
    assign slot_a = slot_of(head_reg, ka_sel);
    assign slot_b = slot_of(head_reg, kb);

    // request checks made in setup
    always_comb
    begin
        go_done    = 1'b0;
        go_read    = 1'b0;
        chk_status = STATUS_OK;
        case (req_reg)
            REQ_INSERT:
            begin
                if (p > n)
                begin
                    go_done    = 1'b1;
                    chk_status = STATUS_RANGE;
                end
                else if (n >= dep)
                begin
                    go_done    = 1'b1;
                    chk_status = STATUS_FULL;
                end
            end
            REQ_ERASE:
            begin
                if (p >= e)
                begin
                    go_done = 1'b1;
                end
                else if (e > n)
                begin
                    go_done    = 1'b1;
                    chk_status = STATUS_RANGE;
                end
            end
            REQ_RESIZE:
            begin
                if (p > dep)
                begin
                    go_done    = 1'b1;
                    chk_status = STATUS_FULL;
                end
            end
            REQ_READ:
            begin
                if (p < n)
                begin
                    go_read = 1'b1;
                end
                else
                begin
                    go_done    = 1'b1;
                    chk_status = STATUS_RANGE;
                end
            end
            default:
            begin
                go_done = 1'b1;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (go_done)
                begin
                    state_next = S_DONE;
                end
                else if (go_read)
                begin
                    state_next = S_RDATA;
                end
                else
                begin
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                if ((moves_reg == '0) && !pend_reg)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_DONE;
            end
            S_RDATA:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        end_next        = end_reg;
        val_next        = val_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        moves_next      = moves_reg;
        dir_up_next     = dir_up_reg;
        fill_next       = fill_reg;
        pend_next       = 1'b0;
        pend_dst_next   = pend_dst_reg;
        kfin_next       = kfin_reg;
        fin_ins_next    = fin_ins_reg;
        fin_head_next   = fin_head_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        data_next       = data_reg;
        mem_we          = 1'b0;
        mem_waddr       = dst_reg;
        mem_wdata       = val_elem;
        mem_re          = 1'b0;
        mem_raddr       = src_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    req_next        = req_type;
                    idx_next        = index;
                    end_next        = end_index;
                    val_next        = value;
                    res_status_next = STATUS_OK;
                    res_pos_next    = '0;
                    res_data_next   = '0;
                    fin_ins_next    = 1'b0;
                    fin_head_next   = 1'b0;
                    fill_next       = 1'b0;
                    moves_next      = '0;
                end
            end
            S_SETUP:
            begin
                res_status_next = chk_status;
                if (go_read)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = slot_a;
                end
                else if (req_reg == REQ_ERASE && p >= e)
                begin
                    res_pos_next = end_reg;
                end
                else if (!go_done)
                begin
                    case (req_reg)
                        REQ_INSERT:
                        begin
                            kfin_next    = p;
                            fin_ins_next = 1'b1;
                            if (ins_front)
                            begin
                                head_next   = step_dn(head_reg);
                                src_next    = head_reg;
                                dst_next    = step_dn(head_reg);
                                dir_up_next = 1'b1;
                                moves_next  = CW'(p);
                            end
                            else
                            begin
                                src_next    = slot_a;
                                dst_next    = slot_b;
                                dir_up_next = 1'b0;
                                moves_next  = CW'(n - p);
                            end
                        end
                        REQ_ERASE:
                        begin
                            res_pos_next = idx_reg;
                            count_next   = CW'(n - (e - p));
                            src_next     = slot_a;
                            dst_next     = slot_b;
                            if (ers_front)
                            begin
                                dir_up_next   = 1'b0;
                                moves_next    = CW'(p);
                                kfin_next     = e - p;
                                fin_head_next = 1'b1;
                            end
                            else
                            begin
                                dir_up_next = 1'b1;
                                moves_next  = CW'(n - e);
                            end
                        end
                        REQ_RESIZE:
                        begin
                            dst_next    = slot_b;
                            dir_up_next = 1'b1;
                            fill_next   = 1'b1;
                            moves_next  = (p > n) ? CW'(p - n) : '0;
                            count_next  = CW'(p);
                        end
                        default:
                        begin
                            moves_next = '0;
                        end
                    endcase
                end
            end
            S_MOVE:
            begin
                if (fill_reg)
                begin
                    // resize growth: one fill write per cycle
                    if (moves_reg != '0)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = dst_reg;
                        mem_wdata  = val_elem;
                        dst_next   = step_up(dst_reg);
                        moves_next = moves_reg - 1'b1;
                    end
                end
                else
                begin
                    // copy: read a slot now, write it in the next cycle
                    if (pend_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = pend_dst_reg;
                        mem_wdata = mem_rdata;
                    end
                    if (moves_reg != '0)
                    begin
                        mem_re        = 1'b1;
                        mem_raddr     = src_reg;
                        pend_next     = 1'b1;
                        pend_dst_next = dst_reg;
                        src_next      = dir_up_reg ? step_up(src_reg) : step_dn(src_reg);
                        dst_next      = dir_up_reg ? step_up(dst_reg) : step_dn(dst_reg);
                        moves_next    = moves_reg - 1'b1;
                    end
                end
            end
            S_LAST:
            begin
                if (fin_ins_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = slot_a;
                    mem_wdata  = val_elem;
                    count_next = count_reg + 1'b1;
                end
                if (fin_head_reg)
                begin
                    head_next = slot_a;
                end
            end
            S_RDATA:
            begin
                res_data_next = rd_wide[VAL_W-1:0];
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    pos_next       = res_pos_reg;
                    cnt_next       = IDX_W'(count_reg);
                    data_next      = res_data_reg;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        end_reg        <= end_next;
        val_reg        <= val_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        moves_reg      <= moves_next;
        dir_up_reg     <= dir_up_next;
        fill_reg       <= fill_next;
        pend_dst_reg   <= pend_dst_next;
        kfin_reg       <= kfin_next;
        fin_ins_reg    <= fin_ins_next;
        fin_head_reg   <= fin_head_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_data_reg   <= res_data_next;
        status_reg     <= status_next;
        pos_reg        <= pos_next;
        cnt_reg        <= cnt_next;
        data_reg       <= data_next;
    end

    // element store
    rdq_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign position_out = pos_reg;
    assign count_out    = cnt_reg;
    assign read_data    = data_reg;

    // count never exceeds the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");

    // an accepted beat always enters setup next
    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == S_SETUP))
        else $error("accepted beat did not enter setup");

    // a pending copy write only exists inside the move loop
    a_pend_move: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_MOVE))
        else $error("pending copy outside move loop");

    // failed requests return no read data
    a_fail_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |-> (read_data == '0))
        else $error("read data on failed request");

endmodule

// File: src/rdq_ram.sv
`timescale 1ns / 1ps

module rdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
